FILE: src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define GFPSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication from a condition to a property in the following cycle
`define GFPSM_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: src/gfpsm_pkg.sv
package gfpsm_pkg;

	localparam int MAX_PAYLOAD_DEF = 2048;
	localparam int HEAD_DEPTH = 17;
	localparam logic [11:0] COUNT_SAT = 12'hFFF;

	typedef enum logic [1:0] {
		VERDICT_EXCLUDED  = 2'd0,
		VERDICT_CANDIDATE = 2'd1,
		VERDICT_DETECTED  = 2'd2
	} verdict_t;

	// signature bytes
	localparam logic [15:0] SIG_HDR_A = 16'h0508;
	localparam logic [15:0] SIG_HDR_B = 16'h04A0;
	localparam logic [15:0] SIG_TAIL = 16'h0194;
	localparam logic [31:0] SIG_CTRL = 32'h0005_0800;
	localparam logic [15:0] SIG_CTRL_ID = 16'h0005;
	localparam logic [7:0] SIG_CTRL_TYPE = 8'h18;
	localparam logic [15:0] SIG_CHAIN = 16'h01B9;
	localparam logic [7:0] SIG_CHAIN_TYPE = 8'h26;
	localparam logic [7:0] SIG_TRAILER = 8'h01;
	localparam int SIG_LONG_LEN = 10;
	localparam logic [7:0] SIG_LONG [SIG_LONG_LEN] = '{
		8'h00, 8'h11, 8'h35, 8'h02, 8'h03, 8'h00, 8'h93, 8'h96, 8'h01, 8'h00
	};

	localparam logic [7:0] CHR_A_UP = 8'h41;
	localparam logic [7:0] CHR_C_UP = 8'h43;
	localparam logic [7:0] CHR_G_UP = 8'h47;
	localparam logic [7:0] CHR_H_UP = 8'h48;
	localparam logic [7:0] CHR_T_UP = 8'h54;
	localparam logic [7:0] CHR_X_UP = 8'h58;
	localparam logic [7:0] CHR_D_LO = 8'h64;
	localparam logic [7:0] CHR_F_LO = 8'h66;
	localparam logic [7:0] CHR_K_LO = 8'h6B;
	localparam logic [7:0] CHR_X_LO = 8'h78;

	typedef struct packed {
		logic [11:0] count;
		logic [HEAD_DEPTH-1:0][7:0] head;
		logic [7:0] tail_prev;
		logic [7:0] tail_last;
		logic [15:0] chain_one;
		logic [15:0] chain_two;
		logic [15:0] block_one;
		logic [15:0] block_two;
		logic [7:0] trailer;
	} flow_state_t;

endpackage

FILE: src/gfpsm_capture.sv
module gfpsm_capture (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	output gfpsm_pkg::flow_state_t upd
);

	gfpsm_pkg::flow_state_t st_q;
	logic [17:0] pos18;
	logic [17:0] blk_one_at;
	logic [17:0] blk_two_at;
	logic [17:0] trl_at;

	assign pos18 = {6'd0, st_q.count};
	assign blk_one_at = {2'd0, st_q.chain_one} + 18'd5;
	assign blk_two_at = {2'd0, st_q.chain_two} + 18'd12;
	// block_two only changes at offsets below the trailer, so old values are exact
	assign trl_at = {2'd0, st_q.chain_two} + {2'd0, st_q.block_two} + 18'd14;

	always_comb begin
		upd = st_q;
		for (int i = 0; i < gfpsm_pkg::HEAD_DEPTH; i++) begin
			if (st_q.count == 12'(i)) upd.head[i] = data_byte;
		end
		if (st_q.count == 12'd3) upd.chain_one[15:8] = data_byte;
		if (st_q.count == 12'd4) upd.chain_one[7:0] = data_byte;
		if (st_q.count == 12'd10) upd.chain_two[15:8] = data_byte;
		if (st_q.count == 12'd11) upd.chain_two[7:0] = data_byte;
		if (pos18 == blk_one_at) upd.block_one[15:8] = data_byte;
		if (pos18 == blk_one_at + 18'd1) upd.block_one[7:0] = data_byte;
		if (pos18 == blk_two_at) upd.block_two[15:8] = data_byte;
		if (pos18 == blk_two_at + 18'd1) upd.block_two[7:0] = data_byte;
		if (pos18 == trl_at) upd.trailer = data_byte;
		upd.tail_prev = st_q.tail_last;
		upd.tail_last = data_byte;
		if (st_q.count != gfpsm_pkg::COUNT_SAT) upd.count = st_q.count + 12'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (go) begin
			// a finished payload leaves a clean slate for the next one
			if (last_byte) st_q <= '0;
			else st_q <= upd;
		end
	end

endmodule

FILE: src/gfpsm_judge.sv
module gfpsm_judge #(
	parameter int MAX_PAYLOAD = gfpsm_pkg::MAX_PAYLOAD_DEF
) (
	input  gfpsm_pkg::flow_state_t st,
	input  logic stage,
	output gfpsm_pkg::verdict_t verdict,
	output logic next_stage
);

	logic [11:0] len;
	logic [17:0] len18;
	logic lenok;
	logic last0;
	logic [7:0] h0;
	logic [7:0] h1;
	logic long_sig;
	logic ctrl_sig;
	logic [17:0] c1_end;
	logic [17:0] c1_tot;
	logic [17:0] c2_end;
	logic [17:0] c2_tot;
	logic [17:0] ctrl_len;
	logic tail_ok;

	assign len = st.count;
	assign len18 = {6'd0, len};
	assign lenok = (len != gfpsm_pkg::COUNT_SAT) && ({4'd0, len} <= 16'(MAX_PAYLOAD));
	assign last0 = (st.tail_last == 8'd0);
	assign h0 = st.head[0];
	assign h1 = st.head[1];
	assign tail_ok = ({st.tail_prev, st.tail_last} == gfpsm_pkg::SIG_TAIL);
	assign c1_end = {2'd0, st.chain_one} + 18'd7;
	assign c1_tot = c1_end + {2'd0, st.block_one};
	assign c2_end = {2'd0, st.chain_two} + 18'd14;
	assign c2_tot = c2_end + 18'd1 + {2'd0, st.block_two};
	assign ctrl_len = {2'd0, st.head[15], st.head[16]} + 18'd17;
	assign ctrl_sig = ({st.head[0], st.head[1], st.head[2], st.head[3]} == gfpsm_pkg::SIG_CTRL)
		&& ({st.head[4], st.head[5]} == gfpsm_pkg::SIG_CTRL_ID)
		&& ({st.head[8], st.head[9]} == gfpsm_pkg::SIG_CTRL_ID)
		&& (st.head[10] == gfpsm_pkg::SIG_CTRL_TYPE);

	always_comb begin
		long_sig = 1'b1;
		for (int i = 0; i < gfpsm_pkg::SIG_LONG_LEN; i++) begin
			if (st.head[i] != gfpsm_pkg::SIG_LONG[i]) long_sig = 1'b0;
		end
	end

	always_comb begin
		verdict = gfpsm_pkg::VERDICT_EXCLUDED;
		if (lenok && len == 12'd13 && {h1, st.head[2]} == gfpsm_pkg::SIG_HDR_A
				&& {st.head[5], st.head[6]} == gfpsm_pkg::SIG_HDR_B && tail_ok) begin
			verdict = gfpsm_pkg::VERDICT_DETECTED;
		end else if (!stage && last0 && (
				(lenok && len == 12'd3 && h0 == gfpsm_pkg::CHR_H_UP
					&& h1 == gfpsm_pkg::CHR_G_UP)
				|| (lenok && len == 12'd35 && h0 == gfpsm_pkg::CHR_H_UP
					&& h1 == gfpsm_pkg::CHR_C_UP)
				|| (len > 12'd2 && h0 == gfpsm_pkg::CHR_A_UP
					&& (h1 inside {gfpsm_pkg::CHR_X_LO, gfpsm_pkg::CHR_X_UP}))
				|| (lenok && len == 12'd12 && h0 == gfpsm_pkg::CHR_A_UP
					&& h1 == gfpsm_pkg::CHR_F_LO)
				|| (len > 12'd2 && h0 == gfpsm_pkg::CHR_A_UP
					&& h1 == gfpsm_pkg::CHR_D_LO))) begin
			verdict = gfpsm_pkg::VERDICT_CANDIDATE;
		end else if (!lenok) begin
			verdict = gfpsm_pkg::VERDICT_EXCLUDED;
		end else if (stage && len == 12'd11 && h0 == gfpsm_pkg::CHR_A_UP
				&& h1 == gfpsm_pkg::CHR_T_UP && st.head[10] == 8'd0) begin
			verdict = gfpsm_pkg::VERDICT_DETECTED;
		end else if (stage && len == 12'd5 && h0 == gfpsm_pkg::CHR_A_UP
				&& st.head[4] == 8'd0
				&& (h1 inside {gfpsm_pkg::CHR_T_UP, gfpsm_pkg::CHR_K_LO})) begin
			verdict = gfpsm_pkg::VERDICT_DETECTED;
		end else if ((len inside {12'd11, 12'd13, 12'd49}) && ctrl_sig) begin
			if (len == 12'd13 && !tail_ok) verdict = gfpsm_pkg::VERDICT_EXCLUDED;
			else if (len == 12'd49 && ctrl_len != len18) verdict = gfpsm_pkg::VERDICT_EXCLUDED;
			else verdict = gfpsm_pkg::VERDICT_DETECTED;
		end else if (len >= 12'd41 && {h0, h1} == gfpsm_pkg::SIG_CHAIN
				&& st.head[2] == gfpsm_pkg::SIG_CHAIN_TYPE && c1_end > len18) begin
			verdict = gfpsm_pkg::VERDICT_EXCLUDED;
		end else if (len >= 12'd41 && {h0, h1} == gfpsm_pkg::SIG_CHAIN
				&& st.head[2] == gfpsm_pkg::SIG_CHAIN_TYPE && c1_tot == len18) begin
			verdict = gfpsm_pkg::VERDICT_DETECTED;
		end else if (len == 12'd56 && long_sig) begin
			// nested chain: header length, then block length, then trailer flag
			if (c2_end > len18 || c2_tot > len18) verdict = gfpsm_pkg::VERDICT_EXCLUDED;
			else if (c2_tot == len18 && st.trailer == gfpsm_pkg::SIG_TRAILER)
				verdict = gfpsm_pkg::VERDICT_DETECTED;
			else verdict = gfpsm_pkg::VERDICT_EXCLUDED;
		end
	end

	assign next_stage = (verdict == gfpsm_pkg::VERDICT_CANDIDATE) ? 1'b1 : stage;

endmodule

FILE: src/game_flow_payload_signature_matcher.sv
// channel   direction  payload                               handshake
// in        input      data_byte, last_byte, flow_stage       in_valid / in_ready
// out       output     verdict, next_stage                    out_valid / out_ready
//
// one byte a cycle unless a last byte waits for a free result register; a byte goes
// through an input register and, if it is the last of a payload, its verdict is
// written into the result register as that byte leaves the input register
// the rate is set by the single capture and rule stage between the two registers
// reset clears the byte count, captured fields and both valid flags
// a stalled result holds only last bytes back; other bytes keep streaming
module game_flow_payload_signature_matcher #(
	parameter int MAX_PAYLOAD = gfpsm_pkg::MAX_PAYLOAD_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	input  logic flow_stage,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] verdict,
	output logic next_stage
);

	logic valid_s1;
	logic [7:0] data_s1;
	logic last_s1;
	logic stage_s1;
	logic out_valid_q;
	logic [1:0] verdict_q;
	logic next_stage_q;
	logic out_free;
	logic s1_go;
	gfpsm_pkg::flow_state_t upd;
	gfpsm_pkg::verdict_t judge_verdict;
	logic judge_stage;

	assign out_free = !out_valid_q || out_ready;
	assign s1_go = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
			stage_s1 <= flow_stage;
		end
	end

	gfpsm_capture u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.go(s1_go),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.upd(upd)
	);

	gfpsm_judge #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_judge (
		.st(upd),
		.stage(stage_s1),
		.verdict(judge_verdict),
		.next_stage(judge_stage)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			verdict_q <= judge_verdict;
			next_stage_q <= judge_stage;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;
	assign next_stage = next_stage_q;

endmodule

FILE: src/gfpsm_checker.sv
`include "assert_macros.svh"

module gfpsm_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] verdict,
	input logic next_stage
);

	// a waiting result holds
	`GFPSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(verdict) && $stable(next_stage), "result changed while stalled")
	// only three verdict codes exist
	`GFPSM_ASSERT(a_verdict_code, out_valid |-> (verdict != 2'd3), "undefined verdict code")
	// a candidate always moves the flow to stage one
	`GFPSM_ASSERT(a_cand_stage, (out_valid && verdict == 2'(gfpsm_pkg::VERDICT_CANDIDATE)) |-> next_stage, "candidate without stage set")

endmodule

bind game_flow_payload_signature_matcher gfpsm_checker u_gfpsm_checker (.*);

FILE: dv/tb_game_flow_payload_signature_matcher.sv
`timescale 1ns / 100ps

module tb_game_flow_payload_signature_matcher;

	localparam int DIR_ROWS = 25;
	localparam int RAND_BYTES = 650;
	localparam int RAND_MIN_VERDICTS = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 500000;
	// small length limit so that over-long payloads stay short
	localparam int TB_MAX_PAYLOAD = 64;

	typedef struct packed {
		gfpsm_pkg::verdict_t vd;
		logic ns;
	} verdict_exp_t;

	typedef struct packed {
		logic stage;
		logic [15:0] len;
		logic [0:16][7:0] head;
		logic [7:0] fill;
		logic typed;
		gfpsm_pkg::verdict_t vd;
		logic ns;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic last_byte = 1'b0;
	logic flow_stage = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] verdict;
	logic next_stage;

	game_flow_payload_signature_matcher #(
		.MAX_PAYLOAD(TB_MAX_PAYLOAD)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.flow_stage (flow_stage),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.verdict    (verdict),
		.next_stage (next_stage)
	);

	always #4 clk = ~clk;

	// payload shapes: head bytes 0..16, fill for the rest
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{1'b0, 16'd1, 136'h0, 8'h00, 1'b1, gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b1, 16'd1, {8'hFF, 128'h0}, 8'h00, 1'b1, gfpsm_pkg::VERDICT_EXCLUDED, 1'b1},
		'{1'b0, 16'd13, {8'h00, 8'h05, 8'h08, 8'h00, 8'h00, 8'h04, 8'hA0, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h01, 8'h94, 32'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_DETECTED, 1'b0},
		'{1'b0, 16'd13, {8'h00, 8'h05, 8'h08, 8'h00, 8'h00, 8'h04, 8'hA0, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h01, 8'h95, 32'h0}, 8'h00, 1'b0,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b0, 16'd3, {8'h48, 8'h47, 120'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_CANDIDATE, 1'b1},
		'{1'b1, 16'd3, {8'h48, 8'h47, 120'h0}, 8'h00, 1'b0,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b0, 16'd35, {8'h48, 8'h43, 120'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_CANDIDATE, 1'b1},
		'{1'b0, 16'd3, {8'h41, 8'h78, 120'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_CANDIDATE, 1'b1},
		'{1'b0, 16'd20, {8'h41, 8'h58, 120'h0}, 8'h00, 1'b0,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b0, 16'd12, {8'h41, 8'h66, 120'h0}, 8'h00, 1'b0,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b0, 16'd3, {8'h41, 8'h64, 120'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_CANDIDATE, 1'b1},
		'{1'b0, 16'd20, {8'h41, 8'h64, 120'h0}, 8'hFF, 1'b0,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b1, 16'd11, {8'h41, 8'h54, 120'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_DETECTED, 1'b1},
		'{1'b1, 16'd5, {8'h41, 8'h6B, 120'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_DETECTED, 1'b1},
		'{1'b1, 16'd5, {8'h41, 8'h54, 120'h0}, 8'h00, 1'b0,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b0, 16'd11, {8'h00, 8'h05, 8'h08, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00,
			8'h05, 8'h18, 48'h0}, 8'h00, 1'b1, gfpsm_pkg::VERDICT_DETECTED, 1'b0},
		'{1'b1, 16'd13, {8'h00, 8'h05, 8'h08, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00,
			8'h05, 8'h18, 48'h0}, 8'h00, 1'b1, gfpsm_pkg::VERDICT_EXCLUDED, 1'b1},
		'{1'b0, 16'd49, {8'h00, 8'h05, 8'h08, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00,
			8'h05, 8'h18, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20}, 8'h00, 1'b0,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b0, 16'd49, {8'h00, 8'h05, 8'h08, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00,
			8'h05, 8'h18, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h21}, 8'h00, 1'b0,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b0, 16'd41, {8'h01, 8'hB9, 8'h26, 8'h00, 8'h00, 8'h00, 8'h22, 80'h0}, 8'h00,
			1'b0, gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b0, 16'd41, {8'h01, 8'hB9, 8'h26, 8'h00, 8'h40, 96'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b0, 16'd56, {8'h00, 8'h11, 8'h35, 8'h02, 8'h03, 8'h00, 8'h93, 8'h96, 8'h01,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 24'h0}, 8'h01, 1'b0,
			gfpsm_pkg::VERDICT_EXCLUDED, 1'b0},
		'{1'b1, 16'd56, {8'h00, 8'h11, 8'h35, 8'h02, 8'h03, 8'h00, 8'h93, 8'h96, 8'h01,
			8'h00, 8'h00, 8'h40, 40'h0}, 8'h00, 1'b1, gfpsm_pkg::VERDICT_EXCLUDED, 1'b1},
		// over-long payloads: only the length-free prefixes can still match
		'{1'b0, 16'd70, {8'h41, 8'h78, 120'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_CANDIDATE, 1'b1},
		'{1'b0, 16'd80, {8'h41, 8'h64, 120'h0}, 8'h00, 1'b1,
			gfpsm_pkg::VERDICT_CANDIDATE, 1'b1}
	};

	// shadow of the per-payload capture state
	logic [11:0] sm_count;
	logic [7:0] sm_head [gfpsm_pkg::HEAD_DEPTH];
	logic [7:0] sm_tail_prev;
	logic [7:0] sm_tail_last;
	logic [15:0] sm_chain_one;
	logic [15:0] sm_chain_two;
	logic [15:0] sm_block_one;
	logic [15:0] sm_block_two;
	logic [7:0] sm_trailer;

	verdict_exp_t pending_verdicts [$];
	logic [7:0] pay_q [$];

	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned verdicts_queued = 0;
	int unsigned payloads_sent = 0;
	int unsigned verdict_tally [3] = '{0, 0, 0};
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int unsigned hold_ask = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	verdict_exp_t got_verdict;

	function automatic void sm_clear();
		sm_count = '0;
		foreach (sm_head[i])
			sm_head[i] = 8'h00;
		sm_tail_prev = 8'h00;
		sm_tail_last = 8'h00;
		sm_chain_one = '0;
		sm_chain_two = '0;
		sm_block_one = '0;
		sm_block_two = '0;
		sm_trailer = 8'h00;
	endfunction

	function automatic logic [15:0] sm_head16(int off);
		return {sm_head[off], sm_head[off + 1]};
	endfunction

	function automatic verdict_exp_t sm_judge(logic stage);
		int len;
		int end_pos;
		bit lenok;
		bit hit;
		bit long_hit;
		logic [7:0] h0;
		logic [7:0] h1;
		verdict_exp_t r;
		len = int'(sm_count);
		lenok = (sm_count != gfpsm_pkg::COUNT_SAT) && (len <= TB_MAX_PAYLOAD);
		h0 = sm_head[0];
		h1 = sm_head[1];
		r.vd = gfpsm_pkg::VERDICT_EXCLUDED;
		r.ns = stage;
		if (lenok && len == 13 && sm_head16(1) == gfpsm_pkg::SIG_HDR_A &&
				sm_head16(5) == gfpsm_pkg::SIG_HDR_B &&
				{sm_tail_prev, sm_tail_last} == gfpsm_pkg::SIG_TAIL) begin
			r.vd = gfpsm_pkg::VERDICT_DETECTED;
			return r;
		end
		if (!stage && sm_tail_last == 8'h00) begin
			hit = (lenok && len == 3 && h0 == gfpsm_pkg::CHR_H_UP &&
					h1 == gfpsm_pkg::CHR_G_UP) ||
				(lenok && len == 35 && h0 == gfpsm_pkg::CHR_H_UP &&
					h1 == gfpsm_pkg::CHR_C_UP) ||
				(len > 2 && h0 == gfpsm_pkg::CHR_A_UP &&
					(h1 == gfpsm_pkg::CHR_X_LO || h1 == gfpsm_pkg::CHR_X_UP)) ||
				(lenok && len == 12 && h0 == gfpsm_pkg::CHR_A_UP &&
					h1 == gfpsm_pkg::CHR_F_LO) ||
				(len > 2 && h0 == gfpsm_pkg::CHR_A_UP && h1 == gfpsm_pkg::CHR_D_LO);
			if (hit) begin
				r.vd = gfpsm_pkg::VERDICT_CANDIDATE;
				r.ns = 1'b1;
				return r;
			end
		end
		if (!lenok)
			return r;
		if (stage && len == 11 && h0 == gfpsm_pkg::CHR_A_UP && h1 == gfpsm_pkg::CHR_T_UP &&
				sm_head[10] == 8'h00) begin
			r.vd = gfpsm_pkg::VERDICT_DETECTED;
			return r;
		end
		if (stage && len == 5 && h0 == gfpsm_pkg::CHR_A_UP && sm_head[4] == 8'h00 &&
				(h1 == gfpsm_pkg::CHR_T_UP || h1 == gfpsm_pkg::CHR_K_LO)) begin
			r.vd = gfpsm_pkg::VERDICT_DETECTED;
			return r;
		end
		if ((len == 11 || len == 13 || len == 49) &&
				sm_head16(0) == gfpsm_pkg::SIG_CTRL[31:16] &&
				sm_head16(2) == gfpsm_pkg::SIG_CTRL[15:0] &&
				sm_head16(4) == gfpsm_pkg::SIG_CTRL_ID &&
				sm_head16(8) == gfpsm_pkg::SIG_CTRL_ID &&
				sm_head[10] == gfpsm_pkg::SIG_CTRL_TYPE) begin
			if (len == 13 && {sm_tail_prev, sm_tail_last} != gfpsm_pkg::SIG_TAIL)
				return r;
			if (len == 49 && int'(sm_head16(15)) + 17 != len)
				return r;
			r.vd = gfpsm_pkg::VERDICT_DETECTED;
			return r;
		end
		if (len >= 41 && sm_head16(0) == gfpsm_pkg::SIG_CHAIN &&
				sm_head[2] == gfpsm_pkg::SIG_CHAIN_TYPE) begin
			if (int'(sm_chain_one) + 7 > len)
				return r;
			if (int'(sm_chain_one) + 7 + int'(sm_block_one) == len) begin
				r.vd = gfpsm_pkg::VERDICT_DETECTED;
				return r;
			end
		end
		long_hit = 1'b1;
		for (int k = 0; k < gfpsm_pkg::SIG_LONG_LEN; k++)
			if (sm_head[k] != gfpsm_pkg::SIG_LONG[k])
				long_hit = 1'b0;
		if (len == 56 && long_hit) begin
			if (int'(sm_chain_two) + 14 > len)
				return r;
			end_pos = int'(sm_chain_two) + 15 + int'(sm_block_two);
			if (end_pos > len)
				return r;
			if (end_pos == len && sm_trailer == gfpsm_pkg::SIG_TRAILER)
				r.vd = gfpsm_pkg::VERDICT_DETECTED;
		end
		return r;
	endfunction

	// one accepted byte: capture, and on the last byte work out the verdict
	function automatic bit sm_take_byte(logic [7:0] b, logic last, logic stage,
			output verdict_exp_t res);
		int p;
		p = int'(sm_count);
		res = '0;
		if (p < gfpsm_pkg::HEAD_DEPTH)
			sm_head[p] = b;
		if (p == 3) sm_chain_one[15:8] = b;
		if (p == 4) sm_chain_one[7:0] = b;
		if (p == 10) sm_chain_two[15:8] = b;
		if (p == 11) sm_chain_two[7:0] = b;
		if (p == 5 + int'(sm_chain_one)) sm_block_one[15:8] = b;
		if (p == 6 + int'(sm_chain_one)) sm_block_one[7:0] = b;
		if (p == 12 + int'(sm_chain_two)) sm_block_two[15:8] = b;
		if (p == 13 + int'(sm_chain_two)) sm_block_two[7:0] = b;
		if (p >= 14 && p == 14 + int'(sm_chain_two) + int'(sm_block_two))
			sm_trailer = b;
		sm_tail_prev = sm_tail_last;
		sm_tail_last = b;
		if (sm_count != gfpsm_pkg::COUNT_SAT)
			sm_count = sm_count + 12'd1;
		if (!last)
			return 1'b0;
		res = sm_judge(stage);
		sm_clear();
		return 1'b1;
	endfunction

	function automatic void put_byte(int idx, logic [7:0] v);
		if (idx < pay_q.size())
			pay_q[idx] = v;
	endfunction

	function automatic void put_word(int idx, logic [15:0] v);
		put_byte(idx, v[15:8]);
		put_byte(idx + 1, v[7:0]);
	endfunction

	// random payload, mostly shaped after one of the signatures
	task automatic build_payload(input bit short_only, output logic stage);
		int kind;
		int len;
		int off;
		int blk;
		kind = short_only ? 0 : $urandom_range(12);
		stage = 1'($urandom_range(1));
		case (kind)
			1: len = 13;
			2: len = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 3;
			3: len = ($urandom_range(3) == 0) ? $urandom_range(34, 36) : 35;
			4, 6: len = $urandom_range(3, 40);
			5: len = ($urandom_range(3) == 0) ? $urandom_range(11, 13) : 12;
			7: len = ($urandom_range(3) == 0) ? $urandom_range(10, 12) : 11;
			8: len = ($urandom_range(3) == 0) ? $urandom_range(4, 6) : 5;
			9: begin
				case ($urandom_range(2))
					0: len = 11;
					1: len = 13;
					default: len = 49;
				endcase
			end
			10: len = $urandom_range(41, TB_MAX_PAYLOAD);
			11: len = ($urandom_range(5) == 0) ? $urandom_range(55, 57) : 56;
			default: begin
				if (short_only)
					len = $urandom_range(1, 3);
				else
					len = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 64);
			end
		endcase
		pay_q.delete();
		for (int i = 0; i < len; i++)
			pay_q.push_back(8'($urandom_range(255)));
		case (kind)
			1: begin
				put_word(1, gfpsm_pkg::SIG_HDR_A);
				put_word(5, gfpsm_pkg::SIG_HDR_B);
				put_word(11, gfpsm_pkg::SIG_TAIL);
			end
			2: begin
				put_byte(0, gfpsm_pkg::CHR_H_UP);
				put_byte(1, gfpsm_pkg::CHR_G_UP);
			end
			3: begin
				put_byte(0, gfpsm_pkg::CHR_H_UP);
				put_byte(1, gfpsm_pkg::CHR_C_UP);
			end
			4: begin
				put_byte(0, gfpsm_pkg::CHR_A_UP);
				put_byte(1, $urandom_range(1) ? gfpsm_pkg::CHR_X_LO : gfpsm_pkg::CHR_X_UP);
			end
			5: begin
				put_byte(0, gfpsm_pkg::CHR_A_UP);
				put_byte(1, gfpsm_pkg::CHR_F_LO);
			end
			6: begin
				put_byte(0, gfpsm_pkg::CHR_A_UP);
				put_byte(1, gfpsm_pkg::CHR_D_LO);
			end
			7: begin
				put_byte(0, gfpsm_pkg::CHR_A_UP);
				put_byte(1, gfpsm_pkg::CHR_T_UP);
				put_byte(10, 8'h00);
			end
			8: begin
				put_byte(0, gfpsm_pkg::CHR_A_UP);
				put_byte(1, $urandom_range(1) ? gfpsm_pkg::CHR_T_UP : gfpsm_pkg::CHR_K_LO);
				put_byte(4, 8'h00);
			end
			9: begin
				put_word(0, gfpsm_pkg::SIG_CTRL[31:16]);
				put_word(2, gfpsm_pkg::SIG_CTRL[15:0]);
				put_word(4, gfpsm_pkg::SIG_CTRL_ID);
				put_word(8, gfpsm_pkg::SIG_CTRL_ID);
				put_byte(10, gfpsm_pkg::SIG_CTRL_TYPE);
				if ($urandom_range(3) != 0)
					put_word(11, gfpsm_pkg::SIG_TAIL);
				put_word(15, ($urandom_range(3) != 0) ? 16'd32 : 16'($urandom_range(40)));
			end
			10: begin
				off = $urandom_range(0, len - 7);
				blk = ($urandom_range(3) == 0) ? $urandom_range(200) : len - 7 - off;
				put_word(0, gfpsm_pkg::SIG_CHAIN);
				put_byte(2, gfpsm_pkg::SIG_CHAIN_TYPE);
				put_word(3, 16'(off));
				put_word(5 + off, 16'(blk));
			end
			11: begin
				off = $urandom_range(0, 41);
				blk = ($urandom_range(4) == 0) ? $urandom_range(60) : 41 - off;
				for (int k = 0; k < gfpsm_pkg::SIG_LONG_LEN; k++)
					put_byte(k, gfpsm_pkg::SIG_LONG[k]);
				put_word(10, 16'(off));
				put_word(12 + off, 16'(blk));
				if ($urandom_range(4) != 0)
					put_byte(55, gfpsm_pkg::SIG_TRAILER);
			end
			default: ;
		endcase
		if (kind >= 2 && kind <= 6) begin
			stage = 1'b0;
			if ($urandom_range(4) != 0)
				pay_q[pay_q.size() - 1] = 8'h00;
		end
		if (kind == 7 || kind == 8)
			stage = 1'b1;
		if (kind >= 2 && kind <= 8 && $urandom_range(4) == 0)
			stage = ~stage;
		// broken sequences: one byte overwritten
		if ($urandom_range(4) == 0)
			pay_q[$urandom_range(pay_q.size() - 1)] = 8'($urandom_range(255));
	endtask

	// stream pay_q as one payload; flow_stage matters only on the last byte
	task automatic send_payload(input logic stage, input logic typed, input verdict_exp_t fixed);
		int n;
		bit got;
		verdict_exp_t res;
		n = pay_q.size();
		for (int i = 0; i < n; i++) begin
			while (!tx_quiet && $urandom_range(99) < 24) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			@(negedge clk);
			in_valid <= 1'b1;
			data_byte <= pay_q[i];
			last_byte <= (i == n - 1);
			flow_stage <= (i == n - 1) ? stage : 1'($urandom_range(1));
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			got = sm_take_byte(pay_q[i], i == n - 1, stage, res);
			bytes_sent++;
			if (got) begin
				pending_verdicts.push_back(typed ? fixed : res);
				verdicts_queued++;
			end
		end
		payloads_sent++;
	endtask

	// result side: random stalls, a quiet stretch and one long hold-off
	always @(negedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_quiet)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(99) >= 24);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: unexpected result verdict=%0d next_stage=%0d", $time, verdict,
					next_stage);
			end else begin
				got_verdict = pending_verdicts.pop_front();
				if (verdict !== got_verdict.vd) begin
					errors++;
					$display("%0t: verdict mismatch, expected %0d, actual %0d", $time,
						got_verdict.vd, verdict);
				end
				if (next_stage !== got_verdict.ns) begin
					errors++;
					$display("%0t: next_stage mismatch, expected %0d, actual %0d", $time,
						got_verdict.ns, next_stage);
				end
				if (verdict < 2'd3)
					verdict_tally[verdict]++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_verdicts.size());
			$display("tb_game_flow_payload_signature_matcher: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned dir_bytes;
		int unsigned dir_verdicts;
		int unsigned pay_idx;
		logic stage;
		verdict_exp_t fixed;
		sm_clear();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			pay_q.delete();
			for (int i = 0; i < dir_tab[r].len; i++)
				pay_q.push_back((i < gfpsm_pkg::HEAD_DEPTH) ? dir_tab[r].head[i] : dir_tab[r].fill);
			fixed.vd = dir_tab[r].vd;
			fixed.ns = dir_tab[r].ns;
			send_payload(dir_tab[r].stage, dir_tab[r].typed, fixed);
		end
		dir_bytes = bytes_sent;
		dir_verdicts = verdicts_queued;

		pay_idx = 0;
		fixed = '0;
		while (bytes_sent - dir_bytes < RAND_BYTES ||
				verdicts_queued - dir_verdicts < RAND_MIN_VERDICTS) begin
			pay_idx++;
			if (pay_idx == 6) begin
				tx_quiet = 1'b1;
				rx_quiet = 1'b1;
			end
			if (pay_idx == 14) begin
				tx_quiet = 1'b0;
				rx_quiet = 1'b0;
			end
			// short payloads against a stalled result side fill the block up
			if (pay_idx == 18) begin
				hold_ask++;
				repeat (25) begin
					build_payload(1'b1, stage);
					send_payload(stage, 1'b0, fixed);
				end
				// then the sender waits until every request has its verdict
				@(negedge clk);
				in_valid <= 1'b0;
				while (pending_verdicts.size() != 0)
					@(posedge clk);
			end
			build_payload(1'b0, stage);
			send_payload(stage, 1'b0, fixed);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d payloads (%0d bytes, over-long included) gave %0d detected,",
			payloads_sent, bytes_sent, verdict_tally[gfpsm_pkg::VERDICT_DETECTED]);
		$display("%0d candidate, %0d excluded verdicts; %0d errors",
			verdict_tally[gfpsm_pkg::VERDICT_CANDIDATE],
			verdict_tally[gfpsm_pkg::VERDICT_EXCLUDED], errors);
		if (errors == 0)
			$display("tb_game_flow_payload_signature_matcher: PASS");
		else
			$display("tb_game_flow_payload_signature_matcher: FAIL");
		$finish;
	end

endmodule
